// ===== sv/aes128_cbc_cipher_defines.svh =====
// assertion macros for the aes-128 cbc block
// used by the controller module; no other dependencies
`ifndef AES128_CBC_CIPHER_DEFINES_SVH
`define AES128_CBC_CIPHER_DEFINES_SVH

// implication checked on every edge outside reset
`define AES_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication checked outside reset
`define AES_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/aes_pkg.sv =====
// shared types, constants and round functions for the aes-128 cbc block
// no dependencies
package aes_pkg;

	localparam int BlockW = 128;
	localparam int HalfW = 64;
	localparam int Rounds = 10;
	localparam int RoundW = 4;
	localparam int AddrW = 6;

	// register byte addresses
	localparam logic [AddrW-1:0] AddrKeyHigh = 6'h00;
	localparam logic [AddrW-1:0] AddrKeyLow = 6'h08;
	localparam logic [AddrW-1:0] AddrIvHigh = 6'h10;
	localparam logic [AddrW-1:0] AddrIvLow = 6'h18;
	localparam logic [AddrW-1:0] AddrDirection = 6'h20;

	typedef struct packed {
		logic [HalfW-1:0] block_high;
		logic [HalfW-1:0] block_low;
		logic start_of_message;
	} in_beat_t;

	typedef struct packed {
		logic [HalfW-1:0] result_high;
		logic [HalfW-1:0] result_low;
	} out_beat_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXPAND,
		ST_ROUND,
		ST_DONE
	} ctrl_state_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic expand;
		logic step;
		logic finish;
		logic [RoundW-1:0] round;
	} dp_cmd_t;

	function automatic logic [7:0] xtime(input logic [7:0] a);
		xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gmul(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		logic [7:0] x;
		acc = 8'h00;
		x = a;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) acc = acc ^ x;
			x = xtime(x);
		end
		gmul = acc;
	endfunction

	function automatic logic [7:0] sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};
		sbox = t[a];
	endfunction

	function automatic logic [7:0] inv_sbox(input logic [7:0] a);
		logic [7:0] t [256];
		t = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
		inv_sbox = t[a];
	endfunction

	// byte i of a block sits at bits 127-8i
	function automatic logic [7:0] byte_of(input logic [BlockW-1:0] s, input int i);
		byte_of = s[BlockW-1-8*i -: 8];
	endfunction

	// one encrypt round without the key add
	function automatic logic [BlockW-1:0] enc_round(input logic [BlockW-1:0] s,
			input logic last);
		logic [7:0] b [16];
		logic [7:0] t [16];
		logic [BlockW-1:0] r;
		for (int i = 0; i < 16; i++) b[i] = sbox(byte_of(s, i));
		for (int c = 0; c < 4; c++)
			for (int k = 0; k < 4; k++) t[c*4+k] = b[((c+k)%4)*4+k];
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) begin
				if (last) r[BlockW-1-8*(c*4+k) -: 8] = t[c*4+k];
				else r[BlockW-1-8*(c*4+k) -: 8] = xtime(t[c*4+k]) ^
					xtime(t[c*4+(k+1)%4]) ^ t[c*4+(k+1)%4] ^
					t[c*4+(k+2)%4] ^ t[c*4+(k+3)%4];
			end
		end
		enc_round = r;
	endfunction

	// inverse shift and sub
	function automatic logic [BlockW-1:0] dec_sub(input logic [BlockW-1:0] s);
		logic [BlockW-1:0] r;
		for (int c = 0; c < 4; c++)
			for (int k = 0; k < 4; k++)
				r[BlockW-1-8*(c*4+k) -: 8] = inv_sbox(byte_of(s, ((c-k+4)%4)*4+k));
		dec_sub = r;
	endfunction

	function automatic logic [BlockW-1:0] inv_mix(input logic [BlockW-1:0] s);
		logic [7:0] col [4];
		logic [BlockW-1:0] r;
		for (int c = 0; c < 4; c++) begin
			for (int k = 0; k < 4; k++) col[k] = byte_of(s, c*4+k);
			for (int k = 0; k < 4; k++)
				r[BlockW-1-8*(c*4+k) -: 8] = gmul(col[k], 8'd14) ^
					gmul(col[(k+1)%4], 8'd11) ^ gmul(col[(k+2)%4], 8'd13) ^
					gmul(col[(k+3)%4], 8'd9);
		end
		inv_mix = r;
	endfunction

	// next round key from the previous one
	function automatic logic [BlockW-1:0] key_next(input logic [BlockW-1:0] k,
			input logic [7:0] rcon);
		logic [31:0] w0, w1, w2, w3, t;
		{w0, w1, w2, w3} = k;
		t = {sbox(w3[23:16]), sbox(w3[15:8]), sbox(w3[7:0]), sbox(w3[31:24])};
		t = t ^ {rcon, 24'h0};
		w0 = w0 ^ t;
		w1 = w1 ^ w0;
		w2 = w2 ^ w1;
		w3 = w3 ^ w2;
		key_next = {w0, w1, w2, w3};
	endfunction

	function automatic logic [7:0] rcon_of(input logic [RoundW-1:0] r);
		logic [7:0] c;
		c = 8'h01;
		for (int i = 1; i < 10; i++) if (i < r) c = xtime(c);
		rcon_of = c;
	endfunction

endpackage

// ===== sv/aes_ctrl.sv =====
// round sequencer for the aes-128 cbc block
// depends on aes_pkg and aes128_cbc_cipher_defines.svh
`include "aes128_cbc_cipher_defines.svh"
module aes_ctrl
	import aes_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  logic decrypt,
	input  logic out_busy,
	output dp_cmd_t cmd
);

	ctrl_state_t state_q, state_d;
	logic [RoundW-1:0] round_q, round_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			round_q <= '0;
		end else begin
			state_q <= state_d;
			round_q <= round_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d = state_q;
		round_d = round_q;
		cmd = '0;
		cmd.round = round_q;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					round_d = RoundW'(1);
					state_d = decrypt ? ST_EXPAND : ST_ROUND;
				end
			end
			// decrypt builds the round key store one key per cycle
			ST_EXPAND: begin
				cmd.expand = 1'b1;
				if (round_q == RoundW'(Rounds)) begin
					round_d = RoundW'(1);
					state_d = ST_ROUND;
				end else begin
					round_d = round_q + RoundW'(1);
				end
			end
			ST_ROUND: begin
				cmd.step = 1'b1;
				if (round_q == RoundW'(Rounds)) state_d = ST_DONE;
				else round_d = round_q + RoundW'(1);
			end
			ST_DONE: begin
				if (!out_busy) begin
					cmd.finish = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	`AES_ASSERT_IMP(a_round_range, state_q == ST_ROUND, round_q >= RoundW'(1) && round_q <= RoundW'(Rounds), "round out of range")
	`AES_ASSERT_NXT(a_load_enters, cmd.load, state_q != ST_IDLE && round_q == RoundW'(1), "load did not start rounds")
	`AES_ASSERT_IMP(a_stall_busy, state_q != ST_IDLE, in_stall, "input taken while busy")

endmodule

// ===== sv/aes_dp.sv =====
// round datapath, key schedule and chaining for the aes-128 cbc block
// depends on aes_pkg
module aes_dp
	import aes_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  dp_cmd_t cmd,
	input  in_beat_t in_beat,
	input  logic [BlockW-1:0] key,
	input  logic [BlockW-1:0] iv,
	input  logic decrypt,
	output logic [BlockW-1:0] result
);

	logic [BlockW-1:0] state_q, rkey_q, chain_q, cin_q, src_q;
	logic dec_q;
	logic [BlockW-1:0] rk [Rounds+1];
	logic [BlockW-1:0] in_blk, ch, cur_key, nxt, rk_fwd;

	assign in_blk = {in_beat.block_high, in_beat.block_low};
	assign ch = in_beat.start_of_message ? iv : chain_q;
	assign rk_fwd = key_next(rkey_q, rcon_of(cmd.round));

	// decrypt reads the schedule backwards
	assign cur_key = dec_q ? rk[RoundW'(Rounds) - cmd.round] : rk_fwd;

	always_comb begin
		if (dec_q) begin
			nxt = dec_sub(state_q) ^ cur_key;
			if (cmd.round != RoundW'(Rounds)) nxt = inv_mix(nxt);
		end else begin
			nxt = enc_round(state_q, cmd.round == RoundW'(Rounds)) ^ cur_key;
		end
	end

	// round key store, one key written per expansion cycle
	always_ff @(posedge clk) begin
		if (cmd.load) rk[0] <= key;
		else if (cmd.expand) rk[cmd.round] <= rk_fwd;
	end

	// block state
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			dec_q <= decrypt;
			cin_q <= ch;
			src_q <= in_blk;
			rkey_q <= key;
			state_q <= decrypt ? in_blk : (in_blk ^ ch ^ key);
		end else if (cmd.expand) begin
			rkey_q <= rk_fwd;
			// last round key is the initial key add for decrypt
			if (cmd.round == RoundW'(Rounds)) state_q <= state_q ^ rk_fwd;
		end else if (cmd.step) begin
			state_q <= nxt;
			rkey_q <= rk_fwd;
		end
	end

	assign result = dec_q ? (state_q ^ cin_q) : state_q;

	// chain value
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) chain_q <= '0;
		else if (cmd.finish) chain_q <= dec_q ? src_q : state_q;
	end

endmodule

// ===== sv/aes128_cbc_cipher.sv =====
// top level of the aes-128 cbc block: register port, controller, datapath
// depends on aes_pkg, aes_ctrl, aes_dp
//  channel | direction | handshake
//  in      | input     | in_valid / in_stall, payload in_data
//  out     | output    | out_valid / out_stall, payload out_data
//  cfg     | input     | apb read and write, pready always high
// encrypt runs from acceptance to result as load, ten rounds, finish
// decrypt first fills the round key store, then runs the same steps
// reset clears control, config registers and chain value to zero
// a stalled result waits in the output register; the next beat may start,
// and its finish waits until the output register empties
module aes128_cbc_cipher
	import aes_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	input  in_beat_t in_data,
	output logic out_valid,
	input  logic out_stall,
	output out_beat_t out_data,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [AddrW-1:0] paddr,
	input  logic [HalfW-1:0] pwdata,
	output logic [HalfW-1:0] prdata,
	output logic pready
);

	logic [HalfW-1:0] key_high_q, key_low_q, iv_high_q, iv_low_q;
	logic direction_q, out_valid_q;
	dp_cmd_t cmd;
	logic [BlockW-1:0] result;
	logic wr;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q <= '0;
			iv_high_q <= '0;
			iv_low_q <= '0;
			direction_q <= 1'b0;
		end else if (wr) begin
			unique case (paddr)
				AddrKeyHigh: key_high_q <= pwdata;
				AddrKeyLow: key_low_q <= pwdata;
				AddrIvHigh: iv_high_q <= pwdata;
				AddrIvLow: iv_low_q <= pwdata;
				AddrDirection: direction_q <= pwdata[0];
				default: ;
			endcase
		end
	end

	// register read
	always_comb begin
		unique case (paddr)
			AddrKeyHigh: prdata = key_high_q;
			AddrKeyLow: prdata = key_low_q;
			AddrIvHigh: prdata = iv_high_q;
			AddrIvLow: prdata = iv_low_q;
			AddrDirection: prdata = {{(HalfW-1){1'b0}}, direction_q};
			default: prdata = '0;
		endcase
	end

	aes_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.decrypt(direction_q), .out_busy(out_valid_q && out_stall), .cmd(cmd)
	);

	aes_dp u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .in_beat(in_data),
		.key({key_high_q, key_low_q}), .iv({iv_high_q, iv_low_q}),
		.decrypt(direction_q), .result(result)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.finish) out_valid_q <= 1'b1;
		else if (!out_stall) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) out_data <= {result[BlockW-1 -: HalfW], result[HalfW-1:0]};
	end

	assign out_valid = out_valid_q;

endmodule

// ===== bench/tb_aes128_cbc_cipher.sv =====
`timescale 1ns / 1ps
// self-checking bench for the aes-128 cbc block: directed and random blocks,
// encrypt and decrypt, several key, iv and direction settings; needs aes_pkg
module tb_aes128_cbc_cipher;
	import aes_pkg::*;

	localparam int LatencyCycles = 13;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_beat_t in_data;
	logic out_valid;
	logic out_stall;
	out_beat_t out_data;
	logic psel;
	logic penable;
	logic pwrite;
	logic [AddrW-1:0] paddr;
	logic [HalfW-1:0] pwdata;
	logic [HalfW-1:0] prdata;
	logic pready;

	aes128_cbc_cipher dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// shadow of the block's registers and chain
	logic [127:0] key_shadow;
	logic [127:0] iv_shadow;
	logic dir_shadow;
	logic [127:0] chain_shadow;

	in_beat_t block_queue[$];
	out_beat_t cipher_expected[$];
	int sender_idle_pct;
	int receiver_idle_pct;
	int failures;

	// round keys from the configured key
	function automatic void expand(input logic [127:0] k, output logic [127:0] rk [11]);
		logic [31:0] w [44];
		logic [31:0] t;
		logic [7:0] rc;
		rc = 8'h01;
		{w[0], w[1], w[2], w[3]} = k;
		for (int i = 4; i < 44; i++) begin
			t = w[i-1];
			if (i % 4 == 0) begin
				t = {t[23:0], t[31:24]};
				t = {sbox(t[31:24]), sbox(t[23:16]), sbox(t[15:8]), sbox(t[7:0])};
				t = t ^ {rc, 24'h0};
				rc = {rc[6:0], 1'b0} ^ (rc[7] ? 8'h1b : 8'h00);
			end
			w[i] = w[i-4] ^ t;
		end
		for (int r = 0; r < 11; r++) rk[r] = {w[4*r], w[4*r+1], w[4*r+2], w[4*r+3]};
	endfunction

	function automatic logic [7:0] gf2(input logic [7:0] a);
		return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [7:0] gfm(input logic [7:0] a, input logic [7:0] b);
		logic [7:0] acc;
		acc = 8'h00;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) acc ^= a;
			a = gf2(a);
		end
		return acc;
	endfunction

	// one cipher or inverse cipher pass over 16 bytes
	function automatic logic [127:0] cipher_block(input logic [127:0] blk, input logic inv);
		logic [127:0] rk [11];
		logic [7:0] s [16];
		logic [7:0] t [16];
		logic [127:0] v;
		int rd;
		expand(key_shadow, rk);
		v = blk ^ rk[inv ? 10 : 0];
		for (int n = 1; n <= 10; n++) begin
			rd = inv ? 10 - n : n;
			for (int i = 0; i < 16; i++) s[i] = v[127-8*i -: 8];
			for (int c = 0; c < 4; c++)
				for (int r = 0; r < 4; r++)
					t[c*4+r] = inv ? inv_sbox(s[((c-r+4)%4)*4+r]) : sbox(s[((c+r)%4)*4+r]);
			if (!inv && n != 10) begin
				for (int c = 0; c < 4; c++)
					for (int r = 0; r < 4; r++)
						s[c*4+r] = gfm(t[c*4+r], 8'd2) ^ gfm(t[c*4+(r+1)%4], 8'd3) ^
							t[c*4+(r+2)%4] ^ t[c*4+(r+3)%4];
			end else begin
				s = t;
			end
			for (int i = 0; i < 16; i++) v[127-8*i -: 8] = s[i];
			v = v ^ rk[rd];
			if (inv && rd != 0) begin
				for (int i = 0; i < 16; i++) t[i] = v[127-8*i -: 8];
				for (int c = 0; c < 4; c++)
					for (int r = 0; r < 4; r++)
						s[c*4+r] = gfm(t[c*4+r], 8'd14) ^ gfm(t[c*4+(r+1)%4], 8'd11) ^
							gfm(t[c*4+(r+2)%4], 8'd13) ^ gfm(t[c*4+(r+3)%4], 8'd9);
				for (int i = 0; i < 16; i++) v[127-8*i -: 8] = s[i];
			end
		end
		return v;
	endfunction

	// cbc step on an accepted beat
	function automatic out_beat_t cbc_step(input in_beat_t b);
		logic [127:0] ch;
		logic [127:0] blk;
		logic [127:0] res;
		ch = b.start_of_message ? iv_shadow : chain_shadow;
		blk = {b.block_high, b.block_low};
		if (!dir_shadow) begin
			res = cipher_block(blk ^ ch, 1'b0);
			chain_shadow = res;
		end else begin
			res = cipher_block(blk, 1'b1) ^ ch;
			chain_shadow = blk;
		end
		return '{result_high: res[127:64], result_low: res[63:0]};
	endfunction

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_data <= '0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) cipher_expected.push_back(cbc_step(in_data));
			if (block_queue.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
				in_valid <= 1'b1;
				in_data <= block_queue.pop_front();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// output monitor and receiver stall
	always @(posedge clk or negedge arst_n) begin
		out_beat_t exp_beat;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (cipher_expected.size() == 0) begin
					$display("%0t unexpected beat actual %h", $time, out_data);
					failures++;
				end else begin
					exp_beat = cipher_expected.pop_front();
					if (exp_beat.result_high !== out_data.result_high) begin
						$display("%0t result_high expected %h actual %h", $time,
							exp_beat.result_high, out_data.result_high);
						failures++;
					end
					if (exp_beat.result_low !== out_data.result_low) begin
						$display("%0t result_low expected %h actual %h", $time,
							exp_beat.result_low, out_data.result_low);
						failures++;
					end
				end
			end
			out_stall <= ($urandom_range(99) < receiver_idle_pct);
		end
	end

	// register write over the apb port
	task automatic reg_write(input logic [AddrW-1:0] addr, input logic [HalfW-1:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		case (addr)
			AddrKeyHigh: key_shadow[127:64] = data;
			AddrKeyLow: key_shadow[63:0] = data;
			AddrIvHigh: iv_shadow[127:64] = data;
			AddrIvLow: iv_shadow[63:0] = data;
			AddrDirection: dir_shadow = data[0];
			default: ;
		endcase
	endtask

	task automatic setup_regs(input logic [127:0] k, input logic [127:0] iv, input logic d);
		reg_write(AddrKeyHigh, k[127:64]);
		reg_write(AddrKeyLow, k[63:0]);
		reg_write(AddrIvHigh, iv[127:64]);
		reg_write(AddrIvLow, iv[63:0]);
		reg_write(AddrDirection, {63'h0, d});
	endtask

	task automatic drain;
		while (block_queue.size() > 0 || in_valid || cipher_expected.size() > 0)
			@(posedge clk);
		repeat (LatencyCycles + 2) @(posedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	function automatic in_beat_t make_beat(input logic [63:0] h, input logic [63:0] l,
			input logic som);
		return '{block_high: h, block_low: l, start_of_message: som};
	endfunction

	// random messages of a few blocks each
	task automatic queue_messages(input int blocks);
		int left;
		int msg;
		left = blocks;
		while (left > 0) begin
			msg = $urandom_range(8, 1);
			for (int i = 0; i < msg && left > 0; i++, left--)
				block_queue.push_back(make_beat(rand64(), rand64(),
					i == 0 ? 1'b1 : ($urandom_range(19) == 0)));
		end
	endtask

	// stimulus
	initial begin
		key_shadow = '0;
		iv_shadow = '0;
		dir_shadow = 1'b0;
		chain_shadow = '0;
		failures = 0;
		sender_idle_pct = 0;
		receiver_idle_pct = 0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset chain with no start flag, all-zero key
		block_queue.push_back(make_beat('0, '0, 1'b0));
		block_queue.push_back(make_beat('1, '1, 1'b0));
		drain();

		// fips 197 style known key, extremes of the fields
		setup_regs(128'h000102030405060708090a0b0c0d0e0f,
			128'hffffffffffffffffffffffffffffffff, 1'b0);
		block_queue.push_back(make_beat(64'h0011223344556677, 64'h8899aabbccddeeff, 1'b1));
		block_queue.push_back(make_beat('1, '1, 1'b0));
		block_queue.push_back(make_beat('0, '0, 1'b0));
		block_queue.push_back(make_beat(64'h8000000000000000, 64'h1, 1'b1));
		drain();

		// key and direction change mid message keep the chain
		reg_write(AddrKeyLow, '1);
		block_queue.push_back(make_beat(64'h5555aaaa5555aaaa, 64'haaaa5555aaaa5555, 1'b0));
		drain();
		reg_write(AddrDirection, {63'h0, 1'b1});
		block_queue.push_back(make_beat(64'h0123456789abcdef, 64'hfedcba9876543210, 1'b0));
		block_queue.push_back(make_beat('1, '0, 1'b1));
		block_queue.push_back(make_beat('0, '1, 1'b0));
		drain();
		setup_regs('1, '0, 1'b1);
		block_queue.push_back(make_beat('0, '0, 1'b1));
		block_queue.push_back(make_beat('1, '1, 1'b0));
		drain();

		// random phases across idling mixes and register settings
		for (int ph = 0; ph < 6; ph++) begin
			case (ph % 3)
				0: begin sender_idle_pct = 25; receiver_idle_pct = 77; end
				1: begin sender_idle_pct = 77; receiver_idle_pct = 25; end
				default: begin sender_idle_pct = 0; receiver_idle_pct = 0; end
			endcase
			setup_regs({rand64(), rand64()}, {rand64(), rand64()}, ph[0]);
			queue_messages(170);
			drain();
		end
		if (failures == 0) begin
			$display("aes128_cbc_cipher verification clean");
		end else begin
			$display("aes128_cbc_cipher verification failed");
		end
		$finish;
	end

	// watchdog
	initial begin
		#20ms;
		$display("aes128_cbc_cipher verification failed");
		$finish;
	end

endmodule
